/* rtl/core/ntc_pkg.sv */
// Package for the numeric type converter: type codes and payload structs.
// No dependencies.
package ntc_pkg;

  localparam logic [3:0] TypeI8  = 4'd0;
  localparam logic [3:0] TypeI16 = 4'd1;
  localparam logic [3:0] TypeI32 = 4'd2;
  localparam logic [3:0] TypeI64 = 4'd3;
  localparam logic [3:0] TypeU8  = 4'd4;
  localparam logic [3:0] TypeU16 = 4'd5;
  localparam logic [3:0] TypeU32 = 4'd6;
  localparam logic [3:0] TypeU64 = 4'd7;
  localparam logic [3:0] TypeF32 = 4'd8;
  localparam logic [3:0] TypeF64 = 4'd9;

  typedef struct packed {
    logic [63:0] value_bits;
    logic [3:0]  source_type;
    logic [3:0]  target_type;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_bits;
    logic [3:0]  result_type;
    logic        invalid;
  } out_item_t;

  function automatic logic [63:0] width_mask(input logic [3:0] t);
    logic [63:0] m;
    begin
      case (t)
        TypeI8, TypeU8:          m = 64'h0000_0000_0000_00FF;
        TypeI16, TypeU16:        m = 64'h0000_0000_0000_FFFF;
        TypeI32, TypeU32, TypeF32: m = 64'h0000_0000_FFFF_FFFF;
        default:                 m = '1;
      endcase
      return m;
    end
  endfunction

endpackage

/* rtl/core/numeric_type_converter.sv */
// Numeric type converter: one item in, one item out.
// Uses ntc_pkg for type codes and payload structs.
//
// Converts a 64-bit raw value between the C integer types and IEEE single and
// double following C implicit conversion rules, rounding float results to
// nearest even. An item is taken every cycle unless the output stalls; the
// input register feeds a registered decode and align stage, then rounding
// and packing fill the output register. Float to integer goes via int64,
// masked to target width; NaN or beyond-int64 values saturate, set invalid.
module numeric_type_converter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ntc_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ntc_pkg::out_item_t out_data_o
);

  // Pipeline: stage A holds the item, stage B holds the normalized form.
  logic               a_valid_q, b_valid_q, o_valid_q;
  ntc_pkg::in_item_t  a_q;
  logic               adv_o, adv_b, adv_a;

  assign adv_o = !o_valid_q || out_ready_i;
  assign adv_b = !b_valid_q || adv_o;
  assign adv_a = !a_valid_q || adv_b;
  assign in_ready_o = adv_a;

  // ---------------- stage 1: decode and normalize to sig/exp ----------------
  // Every nonzero source becomes sign, 64-bit normalized sig (msb set), and
  // an exponent e so that value = sig * 2^(e-63).
  typedef struct packed {
    logic [3:0]  dst;
    logic        pass;
    logic [63:0] pass_val;
    logic        to_int;
    logic        int_src;
    logic [63:0] int_val;
    logic        sgn;
    logic        zero;
    logic        is_inf;
    logic        is_nan;
    logic [51:0] nan_pay;
    logic [63:0] sig;
    logic signed [13:0] ex;
  } mid_t;

  mid_t m_d, m_q;
  logic [3:0]  src, dst;
  logic [63:0] v;
  logic [63:0] raw_sig;
  logic signed [13:0] raw_ex;
  logic [6:0]  lz;
  logic        fe_max, fe_zero;
  logic [51:0] ffrac;
  logic [63:0] nsig;
  logic signed [13:0] nex;
  logic        r53_up;
  logic [53:0] r53;

  always_comb begin
    src = (a_q.source_type > ntc_pkg::TypeF64) ? ntc_pkg::TypeF64 : a_q.source_type;
    dst = (a_q.target_type > ntc_pkg::TypeF64) ? ntc_pkg::TypeF64 : a_q.target_type;
    v = a_q.value_bits & ntc_pkg::width_mask(src);
    case (src)
      ntc_pkg::TypeI8:  v = {{56{v[7]}}, v[7:0]};
      ntc_pkg::TypeI16: v = {{48{v[15]}}, v[15:0]};
      ntc_pkg::TypeI32: v = {{32{v[31]}}, v[31:0]};
      default: ;
    endcase
    m_d = '0;
    m_d.dst = dst;
    m_d.pass = (src == dst);
    m_d.pass_val = v;
    m_d.to_int = (dst < ntc_pkg::TypeF32);
    m_d.int_src = (src < ntc_pkg::TypeF32);
    m_d.int_val = v;
    ffrac = '0;
    raw_sig = '0;
    raw_ex = '0;
    if (src == ntc_pkg::TypeF32) begin
      m_d.sgn = v[31];
      ffrac = {v[22:0], 29'd0};
      fe_max = (v[30:23] == 8'hFF);
      fe_zero = (v[30:23] == 8'h00);
      raw_sig = {fe_zero ? 1'b0 : 1'b1, v[22:0], 40'd0};
      raw_ex = fe_zero ? -14'sd126 : ($signed({6'd0, v[30:23]}) - 14'sd127);
    end else if (src == ntc_pkg::TypeF64) begin
      m_d.sgn = v[63];
      ffrac = v[51:0];
      fe_max = (v[62:52] == 11'h7FF);
      fe_zero = (v[62:52] == 11'h000);
      raw_sig = {fe_zero ? 1'b0 : 1'b1, v[51:0], 11'd0};
      raw_ex = fe_zero ? -14'sd1022 : ($signed({3'd0, v[62:52]}) - 14'sd1023);
    end else begin
      fe_max = 1'b0;
      fe_zero = 1'b0;
      m_d.sgn = (src <= ntc_pkg::TypeI64) && v[63];
      raw_sig = m_d.sgn ? (64'd0 - v) : v;
      raw_ex = 14'sd63;
    end
    m_d.is_nan = fe_max && (ffrac != '0);
    m_d.is_inf = fe_max && (ffrac == '0);
    m_d.nan_pay = ffrac;
    m_d.zero = (raw_sig == '0) && !fe_max;
    lz = '0;
    for (int i = 0; i < 64; i++) begin
      if (raw_sig[i]) lz = 7'(63 - i);
    end
    nsig = raw_sig << lz[5:0];
    nex = raw_ex - $signed({7'd0, lz});
    // Round integer sources to double first when the target is single.
    r53_up = nsig[10] && (nsig[11] || (nsig[9:0] != '0));
    r53 = {1'b0, nsig[63:11]} + {53'd0, r53_up};
    if (m_d.int_src && (dst == ntc_pkg::TypeF32)) begin
      if (r53[53]) begin
        nsig = {1'b1, 63'd0};
        nex = nex + 14'sd1;
      end else begin
        nsig = {r53[52:0], 11'd0};
      end
    end
    m_d.sig = nsig;
    m_d.ex = nex;
  end

  // ---------------- stage 2: round and pack ----------------
  ntc_pkg::out_item_t o_d, o_q;
  logic        tgt32;
  logic [5:0]  fb;
  logic signed [13:0] bias, be, maxe;
  logic [7:0]  shift;
  logic [63:0] kept, rem, half;
  logic        rup;
  logic [63:0] fres, ebase;
  logic [63:0] smask;
  logic [63:0] tmag, itmp;
  logic        inv;

  always_comb begin
    tgt32 = (m_q.dst == ntc_pkg::TypeF32);
    fb    = tgt32 ? 6'd23 : 6'd52;
    bias  = tgt32 ? 14'sd127 : 14'sd1023;
    maxe  = tgt32 ? 14'sd255 : 14'sd2047;
    // Round to the target format; an f32 source fits exactly in f64.
    be = m_q.ex + bias;
    shift = 8'(63 - fb);
    if (be < 14'sd1) shift = 8'(shift + 8'(14'sd1 - be > 14'sd80 ? 14'sd80 : 14'sd1 - be));
    smask = '0;
    if (shift >= 8'd64) begin
      kept = '0;
      rem  = (shift == 8'd64) ? m_q.sig : 64'd0;
      half = (shift == 8'd64) ? {1'b1, 63'd0} : '1;
    end else begin
      kept = m_q.sig >> shift[5:0];
      smask = (64'd1 << shift[5:0]) - 64'd1;
      rem  = m_q.sig & smask;
      half = 64'd1 << (shift[5:0] - 6'd1);
    end
    rup = (rem > half) || ((rem == half) && kept[0]);
    ebase = (be < 14'sd1) ? 64'd0 : 64'(be - 14'sd1);
    fres = (ebase << fb) + kept + {63'd0, rup};
    if (be >= maxe || (fres >> fb) >= 64'(maxe)) fres = 64'(maxe) << fb;
    if (tgt32) begin
      if (m_q.zero) fres = '0;
      else if (m_q.is_inf) fres = 64'h7F80_0000;
      else if (m_q.is_nan) fres = {32'd0, 9'h0FF, 1'b1, m_q.nan_pay[50:29]};
      fres = fres | {32'd0, m_q.sgn, 31'd0};
    end else begin
      if (m_q.zero) fres = '0;
      else if (m_q.is_inf) fres = 64'h7FF0_0000_0000_0000;
      else if (m_q.is_nan) fres = {12'h7FF, 1'b1, m_q.nan_pay[50:0]};
      fres = fres | {m_q.sgn, 63'd0};
    end
    // Truncate toward zero into int64.
    inv = 1'b0;
    tmag = '0;
    if (m_q.ex >= 14'sd0 && m_q.ex < 14'sd64)
      tmag = m_q.sig >> (6'd63 - m_q.ex[5:0]);
    itmp = m_q.sgn ? (64'd0 - tmag) : tmag;
    if (m_q.is_nan) begin
      itmp = {1'b1, 63'd0};
      inv = 1'b1;
    end else if (m_q.is_inf || m_q.ex >= 14'sd63) begin
      if (!(m_q.sgn && !m_q.is_inf && m_q.ex == 14'sd63 && m_q.sig == {1'b1, 63'd0})) inv = 1'b1;
      itmp = m_q.sgn ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else if (m_q.zero) begin
      itmp = '0;
    end
    o_d.result_type = m_q.dst;
    o_d.invalid = 1'b0;
    if (m_q.pass) begin
      o_d.result_bits = m_q.pass_val & ntc_pkg::width_mask(m_q.dst);
    end else if (m_q.to_int) begin
      o_d.result_bits = (m_q.int_src ? m_q.int_val : itmp) & ntc_pkg::width_mask(m_q.dst);
      o_d.invalid = !m_q.int_src && inv;
    end else begin
      o_d.result_bits = fres;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (adv_a) a_valid_q <= in_valid_i;
      if (adv_b) b_valid_q <= a_valid_q;
      if (adv_o) o_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_a && in_valid_i) a_q <= in_data_i;
    if (adv_b && a_valid_q) m_q <= m_d;
    if (adv_o && b_valid_q) o_q <= o_d;
  end

  assign out_valid_o = o_valid_q;
  assign out_data_o  = o_q;

endmodule
